### design/ile_pkg.sv
// Shared constants, codes and types for the indexed list engine.
`default_nettype none

package ile_pkg;

    localparam int CAPACITY = 32;
    localparam int PTR_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int MODE_W   = 2;
    localparam int INDEX_W  = 6;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 3;
    localparam int FIDX_W   = 5;
    localparam int OCNT_W   = 6;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_SEARCH = 2'd3
    } ile_mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 3'd0,
        ST_FULL     = 3'd1,
        ST_RANGE    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FOUND    = 3'd4
    } ile_status_t;

    typedef struct packed {
        ile_status_t         status;
        logic [FIDX_W-1:0]   found_index;
        logic [OCNT_W-1:0]   count;
        logic                last;
    } ile_result_t;

endpackage

`default_nettype wire

### design/ile_in_if.sv
// Input channel: one list operation per item.
`default_nettype none

interface ile_in_if;
    import ile_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic [INDEX_W-1:0]       index;
    logic signed [VAL_W-1:0]  value;

    modport source (output valid, output mode, output index, output value, input ready);
    modport sink   (input valid, input mode, input index, input value, output ready);
endinterface

`default_nettype wire

### design/ile_out_if.sv
// Output channel: one result per transfer; a search item can give several.
`default_nettype none

interface ile_out_if;
    import ile_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [FIDX_W-1:0]    found_index;
    logic [OCNT_W-1:0]    count;
    logic                 last;

    modport source (output valid, output status, output found_index, output count,
                    output last, input ready);
    modport sink   (input valid, input status, input found_index, input count,
                    input last, output ready);
endinterface

`default_nettype wire

### design/ile_out_reg.sv
// Output holding register between the sequencer and the result channel.
`default_nettype none

module ile_out_reg (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push_valid,
    output      logic                push_ready,
    input  wire ile_pkg::ile_result_t push_data,
    ile_out_if.source                out_ch
);
    import ile_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    ile_result_t data_reg;

    assign push_ready = !valid_reg || out_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (push_valid && push_ready)
        begin
            valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid && push_ready)
        begin
            data_reg <= push_data;
        end
    end

    assign out_ch.valid       = valid_reg;
    assign out_ch.status      = data_reg.status;
    assign out_ch.found_index = data_reg.found_index;
    assign out_ch.count       = data_reg.count;
    assign out_ch.last        = data_reg.last;

endmodule

`default_nettype wire

### design/indexed_list_engine.sv
// Indexed list engine: fixed-capacity ordered list of signed 32-bit values with
// append, insert, remove and search. Entries live in a one-write, one-read RAM
// with a registered read port; every move or compare of a stored entry goes
// through a read state and an evaluate state on the same port. Append, insert
// at the count and every rejected item are answered straight from idle. Insert
// below the count shifts the entries from the index up one place, starting at
// the tail; remove shifts later entries down; search scans all held entries.
// One item at a time: in_ch.ready is low while an item is being worked. A
// search gives one result per matching position in ascending order, last marked
// on the final one, or a single not-found result. Every result carries the
// count held after the item.
`default_nettype none

module indexed_list_engine (
    input  wire logic clk,
    input  wire logic rst_n,
    ile_in_if.sink    in_ch,
    ile_out_if.source out_ch
);
    import ile_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_EVAL  = 4'b0100,
        S_FINAL = 4'b1000
    } ile_state_t;

    ile_state_t              state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [PTR_W-1:0]        ptr_reg, ptr_next;
    ile_mode_t               mode_reg, mode_next;
    logic                    pend_reg, pend_next;
    logic [PTR_W-1:0]        pend_pos_reg, pend_pos_next;
    logic [PTR_W-1:0]        idx_reg, idx_next;
    logic signed [VAL_W-1:0] val_reg, val_next;

    logic signed [VAL_W-1:0] mem [CAPACITY];
    logic signed [VAL_W-1:0] rd_data_reg;
    logic                    mem_we;
    logic [PTR_W-1:0]        mem_wa;
    logic signed [VAL_W-1:0] mem_wd;
    logic                    rd_en;
    logic [PTR_W-1:0]        rd_addr;

    logic                    push_valid;
    logic                    push_ready;
    ile_result_t             res;
    ile_mode_t               in_mode;
    logic                    full;
    logic                    match;
    logic                    at_end;

    assign in_mode = ile_mode_t'(in_ch.mode);
    assign full    = (cnt_reg == CNT_W'(CAPACITY));
    assign match   = (rd_data_reg == val_reg);
    assign at_end  = (CNT_W'(ptr_reg) == cnt_reg - 1'b1);

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        ptr_next      = ptr_reg;
        mode_next     = mode_reg;
        pend_next     = pend_reg;
        pend_pos_next = pend_pos_reg;
        idx_next      = idx_reg;
        val_next      = val_reg;
        mem_we        = 1'b0;
        mem_wa        = ptr_reg;
        mem_wd        = val_reg;
        rd_en         = 1'b0;
        rd_addr       = ptr_reg;
        push_valid    = 1'b0;
        in_ch.ready   = 1'b0;
        res.status      = ST_DONE;
        res.found_index = '0;
        res.count       = OCNT_W'(cnt_reg);
        res.last        = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                in_ch.ready = push_ready;
                if (in_ch.valid && push_ready)
                begin
                    mode_next = in_mode;
                    idx_next  = PTR_W'(in_ch.index);
                    val_next  = in_ch.value;
                    case (in_mode)
                        MODE_APPEND:
                        begin
                            push_valid = 1'b1;
                            if (full)
                            begin
                                res.status = ST_FULL;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_wa    = PTR_W'(cnt_reg);
                                mem_wd    = in_ch.value;
                                cnt_next  = cnt_reg + 1'b1;
                                res.count = OCNT_W'(cnt_next);
                            end
                        end
                        MODE_INSERT:
                        begin
                            if (full)
                            begin
                                push_valid = 1'b1;
                                res.status = ST_FULL;
                            end
                            else if (in_ch.index > cnt_reg)
                            begin
                                push_valid = 1'b1;
                                res.status = ST_RANGE;
                            end
                            else if (in_ch.index == cnt_reg)
                            begin
                                push_valid = 1'b1;
                                mem_we     = 1'b1;
                                mem_wa     = PTR_W'(cnt_reg);
                                mem_wd     = in_ch.value;
                                cnt_next   = cnt_reg + 1'b1;
                                res.count  = OCNT_W'(cnt_next);
                            end
                            else
                            begin
                                ptr_next   = PTR_W'(cnt_reg);
                                state_next = S_READ;
                            end
                        end
                        MODE_REMOVE:
                        begin
                            if (in_ch.index >= cnt_reg)
                            begin
                                push_valid = 1'b1;
                                res.status = ST_RANGE;
                            end
                            else
                            begin
                                ptr_next = PTR_W'(in_ch.index);
                                if (in_ch.index == cnt_reg - 1'b1)
                                begin
                                    state_next = S_FINAL;
                                end
                                else
                                begin
                                    state_next = S_READ;
                                end
                            end
                        end
                        default:
                        begin
                            if (cnt_reg == '0)
                            begin
                                push_valid = 1'b1;
                                res.status = ST_NOTFOUND;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                pend_next  = 1'b0;
                                state_next = S_READ;
                            end
                        end
                    endcase
                end
            end

            S_READ:
            begin
                rd_en = 1'b1;
                case (mode_reg)
                    MODE_INSERT: rd_addr = ptr_reg - 1'b1;
                    MODE_REMOVE: rd_addr = ptr_reg + 1'b1;
                    default:     rd_addr = ptr_reg;
                endcase
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                case (mode_reg)
                    MODE_INSERT:
                    begin
                        mem_we   = 1'b1;
                        mem_wa   = ptr_reg;
                        mem_wd   = rd_data_reg;
                        ptr_next = ptr_reg - 1'b1;
                        state_next = (ptr_next == idx_reg) ? S_FINAL : S_READ;
                    end
                    MODE_REMOVE:
                    begin
                        mem_we   = 1'b1;
                        mem_wa   = ptr_reg;
                        mem_wd   = rd_data_reg;
                        ptr_next = ptr_reg + 1'b1;
                        state_next = (CNT_W'(ptr_reg) + 2'd2 == cnt_reg) ? S_FINAL : S_READ;
                    end
                    default:
                    begin
                        if (!(match && pend_reg && !push_ready))
                        begin
                            if (match && pend_reg)
                            begin
                                push_valid      = 1'b1;
                                res.status      = ST_FOUND;
                                res.found_index = FIDX_W'(pend_pos_reg);
                                res.last        = 1'b0;
                            end
                            if (match)
                            begin
                                pend_next     = 1'b1;
                                pend_pos_next = ptr_reg;
                            end
                            if (at_end)
                            begin
                                state_next = S_FINAL;
                            end
                            else
                            begin
                                ptr_next   = ptr_reg + 1'b1;
                                state_next = S_READ;
                            end
                        end
                    end
                endcase
            end

            S_FINAL:
            begin
                if (push_ready)
                begin
                    push_valid = 1'b1;
                    state_next = S_IDLE;
                    case (mode_reg)
                        MODE_INSERT:
                        begin
                            mem_we    = 1'b1;
                            mem_wa    = idx_reg;
                            mem_wd    = val_reg;
                            cnt_next  = cnt_reg + 1'b1;
                            res.count = OCNT_W'(cnt_next);
                        end
                        MODE_REMOVE:
                        begin
                            cnt_next  = cnt_reg - 1'b1;
                            res.count = OCNT_W'(cnt_next);
                        end
                        default:
                        begin
                            if (pend_reg)
                            begin
                                res.status      = ST_FOUND;
                                res.found_index = FIDX_W'(pend_pos_reg);
                            end
                            else
                            begin
                                res.status = ST_NOTFOUND;
                            end
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ptr_reg   <= '0;
            mode_reg  <= MODE_APPEND;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ptr_reg   <= ptr_next;
            mode_reg  <= mode_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_pos_reg <= pend_pos_next;
        idx_reg      <= idx_next;
        val_reg      <= val_next;
    end

    // entry store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    ile_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (res),
        .out_ch     (out_ch)
    );

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (cnt_reg == $past(cnt_reg)) || (cnt_reg == $past(cnt_reg) + 1'b1) ||
                 (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("entry count moved by more than one");

    a_search_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) && (mode_reg == MODE_SEARCH) |=> cnt_reg == $past(cnt_reg))
        else $error("count changed during search");

    a_search_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL) && (mode_reg == MODE_SEARCH) |-> CNT_W'(ptr_reg) < cnt_reg)
        else $error("search pointer past held entries");

    a_push_ok: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> push_ready)
        else $error("result pushed into a full output register");

endmodule

`default_nettype wire

### sim/tb_top.sv
// Testbench for indexed_list_engine: random and directed list operations, checked against a list predictor.
`timescale 1ns / 100ps

module tb_top;
    import ile_pkg::*;

    localparam int RANDOM_ITEMS = 500;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE       = 2 * CAPACITY + 16;

    class list_scoreboard;
        logic signed [VAL_W-1:0] slots [CAPACITY];
        int unsigned             held;
        ile_result_t             awaited [$];
        int unsigned             failures;

        function new();
            held     = 0;
            failures = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void add_expect(ile_status_t st, int unsigned pos, bit fin);
            ile_result_t r;
            r.status      = st;
            r.found_index = pos[FIDX_W-1:0];
            r.count       = held[OCNT_W-1:0];
            r.last        = fin;
            awaited.push_back(r);
        endfunction

        function void note_item(ile_mode_t mode, logic [INDEX_W-1:0] index,
                                logic signed [VAL_W-1:0] value);
            int unsigned hits [$];
            int unsigned i;
            case (mode)
                MODE_APPEND:
                begin
                    if (held >= CAPACITY)
                        add_expect(ST_FULL, 0, 1'b1);
                    else
                    begin
                        slots[held] = value;
                        held++;
                        add_expect(ST_DONE, 0, 1'b1);
                    end
                end
                MODE_INSERT:
                begin
                    if (held >= CAPACITY)
                        add_expect(ST_FULL, 0, 1'b1);
                    else if (index > held)
                        add_expect(ST_RANGE, 0, 1'b1);
                    else
                    begin
                        for (i = held; i > index; i--)
                            slots[i] = slots[i-1];
                        slots[index] = value;
                        held++;
                        add_expect(ST_DONE, 0, 1'b1);
                    end
                end
                MODE_REMOVE:
                begin
                    if (index >= held)
                        add_expect(ST_RANGE, 0, 1'b1);
                    else
                    begin
                        for (i = index; i + 1 < held; i++)
                            slots[i] = slots[i+1];
                        held--;
                        add_expect(ST_DONE, 0, 1'b1);
                    end
                end
                default:
                begin
                    for (i = 0; i < held; i++)
                        if (slots[i] == value)
                            hits.push_back(i);
                    if (hits.size() == 0)
                        add_expect(ST_NOTFOUND, 0, 1'b1);
                    else
                        foreach (hits[k])
                            add_expect(ST_FOUND, hits[k], k == hits.size() - 1);
                end
            endcase
        endfunction

        function void check_result(ile_result_t got);
            ile_result_t exp;
            bit          bad;
            bad = 1'b0;
            if (awaited.size() == 0)
            begin
                $error("unexpected result: status %0d found_index %0d count %0d last %0d",
                       got.status, got.found_index, got.count, got.last);
                failures++;
                return;
            end
            exp = awaited.pop_front();
            if (got.status !== exp.status)
            begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                bad = 1'b1;
            end
            if (got.found_index !== exp.found_index)
            begin
                $error("found_index: expected %0d, got %0d", exp.found_index, got.found_index);
                bad = 1'b1;
            end
            if (got.count !== exp.count)
            begin
                $error("count: expected %0d, got %0d", exp.count, got.count);
                bad = 1'b1;
            end
            if (got.last !== exp.last)
            begin
                $error("last: expected %0d, got %0d", exp.last, got.last);
                bad = 1'b1;
            end
            if (bad)
                failures++;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   idle_on;
    int   stall_order;
    int   random_sent;
    int   cycles;

    logic signed [VAL_W-1:0] pool [6];
    int                      pool_n;

    list_scoreboard list_sb = new();

    ile_in_if  in_ch ();
    ile_out_if out_ch ();

    indexed_list_engine dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    // receiver: random back-pressure plus long hold-offs on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                list_sb.check_result({out_ch.status, out_ch.found_index, out_ch.count,
                                      out_ch.last});
            if (stall_order > 0)
            begin
                hold_left   = stall_order;
                stall_order = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= idle_on ? ($urandom_range(0, 99) >= 14) : 1'b1;
        end
    end

    task automatic send_item(ile_mode_t m, logic [INDEX_W-1:0] idx,
                             logic signed [VAL_W-1:0] v);
        while (idle_on && $urandom_range(0, 99) < 14)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode  <= m;
        in_ch.index <= idx;
        in_ch.value <= v;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        list_sb.note_item(m, idx, v);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (list_sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_extreme();
        case ($urandom_range(0, 3))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sh0;
            default: return -32'sd1;
        endcase
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return pool[$urandom_range(0, pool_n - 1)];
        else if (r < 80)
            return pick_extreme();
        else
            return $urandom;
    endfunction

    task automatic random_item(int grow_pct);
        ile_mode_t          m;
        logic [INDEX_W-1:0] idx;
        int unsigned        n;
        int                 r;
        n = list_sb.held;
        if ($urandom_range(0, 99) < 15)
            m = MODE_SEARCH;
        else if ($urandom_range(0, 99) < grow_pct)
            m = $urandom_range(0, 1) ? MODE_INSERT : MODE_APPEND;
        else
            m = MODE_REMOVE;
        r = $urandom_range(0, 99);
        if (r < 8 || m == MODE_APPEND || m == MODE_SEARCH)
            idx = INDEX_W'($urandom_range(0, 63));
        else if (r < 14)
            idx = INDEX_W'(n + 1);
        else if (m == MODE_INSERT)
            idx = INDEX_W'($urandom_range(0, n));
        else
            idx = (n > 0) ? INDEX_W'($urandom_range(0, n - 1)) : '0;
        send_item(m, idx, pick_value());
        random_sent++;
    endtask

    initial
    begin
        logic signed [VAL_W-1:0] fill_val;
        int                      phase;
        int                      grow_pct;
        int                      len;
        rst_n       <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.mode  <= MODE_APPEND;
        in_ch.index <= '0;
        in_ch.value <= '0;
        idle_on     = 1'b1;
        stall_order = 0;
        random_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(MODE_SEARCH, 6'd0,  32'sd0);
        send_item(MODE_REMOVE, 6'd0,  32'sd0);
        send_item(MODE_INSERT, 6'd1,  32'sd7);
        send_item(MODE_INSERT, 6'd0,  32'sh8000_0000);
        send_item(MODE_APPEND, 6'd63, 32'sh7fff_ffff);
        send_item(MODE_INSERT, 6'd2,  -32'sd1);
        send_item(MODE_INSERT, 6'd1,  32'sd5);
        send_item(MODE_APPEND, 6'd0,  32'sd5);
        send_item(MODE_INSERT, 6'd0,  32'sd5);
        send_item(MODE_SEARCH, 6'd63, 32'sd5);
        send_item(MODE_SEARCH, 6'd0,  32'sh8000_0000);
        send_item(MODE_SEARCH, 6'd0,  32'sd0);
        send_item(MODE_REMOVE, 6'd63, 32'sd0);
        send_item(MODE_INSERT, 6'd63, 32'sd0);
        send_item(MODE_REMOVE, 6'd5,  32'sd0);
        send_item(MODE_REMOVE, 6'd0,  32'sd0);
        send_item(MODE_SEARCH, 6'd0,  -32'sd1);
        send_item(MODE_REMOVE, 6'd4,  32'sd0);
        send_item(MODE_INSERT, 6'd5,  32'sd0);
        send_item(MODE_SEARCH, 6'd0,  32'sh7fff_ffff);
        repeat (4)
            send_item(MODE_REMOVE, 6'd0, 32'sd0);

        // fill with one value: full rejects, then a search that matches every entry
        fill_val = $urandom;
        while (list_sb.held < CAPACITY)
        begin
            if ($urandom_range(0, 1))
                send_item(MODE_APPEND, INDEX_W'($urandom_range(0, 63)), fill_val);
            else
                send_item(MODE_INSERT, INDEX_W'($urandom_range(0, list_sb.held)), fill_val);
            random_sent++;
        end
        send_item(MODE_APPEND, 6'd0, fill_val);
        send_item(MODE_INSERT, 6'd63, fill_val);
        send_item(MODE_INSERT, 6'd0, $urandom);
        send_item(MODE_SEARCH, INDEX_W'($urandom_range(0, 63)), fill_val);
        random_sent += 4;

        phase = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            if (phase % 3 == 1)
                wait_drained();
            idle_on = !(phase == 4 || phase == 5);
            if (phase == 2)
                stall_order = 400;
            pool_n = $urandom_range(1, 6);
            foreach (pool[j])
                pool[j] = ($urandom_range(0, 3) == 0) ? pick_extreme() : $signed($urandom);
            case ($urandom_range(0, 2))
                0:       grow_pct = 80;
                1:       grow_pct = 25;
                default: grow_pct = 55;
            endcase
            len = $urandom_range(20, 60);
            repeat (len)
                random_item(grow_pct);
            phase++;
        end

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (list_sb.failures == 0 && list_sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
